### rtl/rsc_pkg.sv
// Shared types, widths and codes for the readability score counter.
package rsc_pkg;

  // Counter width and derived datapath widths
  localparam int COUNT_BITS = 24;
  localparam int FIELD_BITS = 24;
  localparam int SCORE_BITS = 24;
  // Widest dividend: 433162 * (2^COUNT_BITS - 1) fits in COUNT_BITS + 19 bits
  localparam int DIV_NUM_W  = COUNT_BITS + 19;
  // Widest divisor: 200 * (2^COUNT_BITS - 1) fits in COUNT_BITS + 8 bits
  localparam int DIV_DEN_W  = COUNT_BITS + 8;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    count_t words;
    count_t sentences;
    count_t vowels;
    count_t pairs;
  } counts_t;

  // Error codes on the result channel
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_NO_WORDS     = 2'd1;
  localparam logic [1:0] ERR_NO_SENTENCES = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYL,
    ST_MUL1,
    ST_LD1,
    ST_WAIT1,
    ST_MUL2,
    ST_LD2,
    ST_WAIT2
  } state_t;

endpackage

### rtl/rsc_in_if.sv
// Text byte channel: valid/ready handshake with one byte and an end-of-text mark.
interface rsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

### rtl/rsc_out_if.sv
// Result channel: valid/ready handshake with score, counts and error code.
interface rsc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] score;
  logic [23:0] words;
  logic [23:0] sentences;
  logic [23:0] syllables;
  logic [1:0]  error;

  modport source (output valid, output score, output words, output sentences,
                  output syllables, output error, input ready);
  modport sink   (input valid, input score, input words, input sentences,
                  input syllables, input error, output ready);
endinterface

### rtl/readability_score_counter_unit.sv
// Top level of the readability score counter: byte counting, sequencer and result register.
//
// Usage
//   text   : sink channel, one byte (ch) per transfer; last marks the final byte of a text.
//   result : source channel, one transfer per text carrying the score (signed Q15.8,
//            saturated), the word, sentence and syllable counts and an error code
//            (no words, or no sentences; the score then reads zero).
// Throughput
//   Ordinary bytes are counted at one per cycle with text.ready held high.
//   A byte marked last starts the score: one shared restoring divider works out
//   84.6*syl/words and then 1.015*words/sentences, one quotient bit per cycle over
//   COUNT_BITS+19 bits. An error code is returned without dividing. text.ready
//   stays low from the last byte until the result is loaded.
// Stalls
//   The result sits in an output register until it is taken. Counting of the next
//   text goes on meanwhile; a further last byte waits with its finished score
//   until the register frees.
// Reset
//   rst is synchronous and active high; it clears all counts, the sequencer and
//   the result valid flag.
module readability_score_counter_unit (
  input  logic      clk,
  input  logic      rst,
  rsc_in_if.sink    text,
  rsc_out_if.source result
);
  import rsc_pkg::*;

  localparam int ACC_W = DIV_NUM_W + 2;
  // 206.835 * 256, rounded
  localparam logic signed [ACC_W-1:0] SCORE_BASE = ACC_W'(52950);
  localparam logic signed [ACC_W-1:0] SCORE_MAX  = ACC_W'((1 << (SCORE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SCORE_MIN  = -ACC_W'(1 << (SCORE_BITS - 1));
  // T1 = (K_T1*syl + D_T1*w) / (2*D_T1*w): 84.6*256 rounded, ties up
  localparam int K_T1 = 433152;
  localparam int D_T1 = 10;
  // T2 = (K_T2*w + D_T2*n) / (2*D_T2*n): 1.015*256 rounded, ties up
  localparam int K_T2 = 51968;
  localparam int D_T2 = 100;
  localparam logic [31:0] FIELD_MAX = 32'((64'd1 << FIELD_BITS) - 1);

  function automatic logic [FIELD_BITS-1:0] clamp_field(count_t v);
    logic [31:0] ve;
    ve = 32'(v);
    return (ve > FIELD_MAX) ? FIELD_BITS'(FIELD_MAX) : ve[FIELD_BITS-1:0];
  endfunction

  state_t                 state, state_next;
  counts_t                counts_next;
  counts_t                snap;
  count_t                 syl;
  logic [1:0]             err;
  logic [DIV_NUM_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic                   in_xfer;
  logic                   out_free;
  logic                   load_out;
  logic                   div_start;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic [DIV_NUM_W-1:0]   div_q;
  count_t                 syl_raw;
  logic [SCORE_BITS-1:0]  score_sat;
  logic                   u_divider_idle_q;

  assign in_xfer  = text.valid && text.ready;
  assign out_free = !result.valid || result.ready;

  rsc_counter u_counter (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_xfer),
    .last       (text.last),
    .ch         (text.ch),
    .counts_next(counts_next)
  );

  rsc_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (div_num),
    .den     (div_den),
    .done    (div_done),
    .quotient(div_q)
  );

  // Syllables: vowels less diphthongs, floored at zero, raised to the word count
  always_comb begin
    syl_raw = (snap.vowels > snap.pairs) ? COUNT_BITS'(snap.vowels - snap.pairs) : '0;
    if (syl_raw < snap.words) begin
      syl_raw = snap.words;
    end
  end

  // Saturate the score accumulator into Q15.8
  always_comb begin
    if (acc > SCORE_MAX) begin
      score_sat = SCORE_MAX[SCORE_BITS-1:0];
    end else if (acc < SCORE_MIN) begin
      score_sat = SCORE_MIN[SCORE_BITS-1:0];
    end else begin
      score_sat = acc[SCORE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, ready, divider operands and result load
  always_comb begin
    state_next = state;
    text.ready = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        text.ready = 1'b1;
        if (in_xfer && text.last) begin
          state_next = ST_SYL;
        end
      end
      ST_SYL: begin
        if (snap.words == '0 || snap.sentences == '0) begin
          // error result: nothing to divide, deliver once the register frees
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        state_next = ST_LD1;
      end
      ST_LD1: begin
        div_start  = 1'b1;
        div_num    = DIV_NUM_W'(prod + DIV_NUM_W'(snap.words) * DIV_NUM_W'(D_T1));
        div_den    = DIV_DEN_W'(DIV_DEN_W'(snap.words) * DIV_DEN_W'(2 * D_T1));
        state_next = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (div_done) begin
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        state_next = ST_LD2;
      end
      ST_LD2: begin
        div_start  = 1'b1;
        div_num    = DIV_NUM_W'(prod + DIV_NUM_W'(snap.sentences) * DIV_NUM_W'(D_T2));
        div_den    = DIV_DEN_W'(DIV_DEN_W'(snap.sentences) * DIV_DEN_W'(2 * D_T2));
        state_next = ST_WAIT2;
      end
      ST_WAIT2: begin
        // hold the finished score here until the result register frees
        if (u_divider_idle_q && out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Second quotient folded into the accumulator; flag it for the result load
  always_ff @(posedge clk) begin
    if (rst) begin
      u_divider_idle_q <= 1'b0;
    end else if (state == ST_LD2) begin
      u_divider_idle_q <= 1'b0;
    end else if (state == ST_WAIT2 && div_done) begin
      u_divider_idle_q <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && text.last) begin
      snap <= counts_next;
    end
    unique case (state)
      ST_SYL: begin
        syl <= syl_raw;
        if (snap.words == '0) begin
          err <= ERR_NO_WORDS;
        end else if (snap.sentences == '0) begin
          err <= ERR_NO_SENTENCES;
        end else begin
          err <= ERR_OK;
        end
        if (!(snap.words == '0 || snap.sentences == '0)) begin
          prod <= DIV_NUM_W'(DIV_NUM_W'(syl_raw) * DIV_NUM_W'(K_T1));
        end
      end
      ST_WAIT1: begin
        if (div_done) begin
          acc <= SCORE_BASE - $signed({2'b00, div_q});
        end
      end
      ST_MUL2: begin
        prod <= DIV_NUM_W'(DIV_NUM_W'(snap.words) * DIV_NUM_W'(K_T2));
      end
      ST_WAIT2: begin
        if (div_done) begin
          acc <= acc - $signed({2'b00, div_q});
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: load a finished result, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.words     <= clamp_field(snap.words);
      result.sentences <= clamp_field(snap.sentences);
      if (state == ST_SYL) begin
        // error path: syllables straight from the counts, score zero
        result.syllables <= clamp_field(syl_raw);
        result.score     <= '0;
        result.error     <= (snap.words == '0) ? ERR_NO_WORDS : ERR_NO_SENTENCES;
      end else begin
        result.syllables <= clamp_field(syl);
        result.score     <= score_sat;
        result.error     <= err;
      end
    end
  end

endmodule

### rtl/rsc_counter.sv
// Per-byte word, sentence, vowel and diphthong counters.
module rsc_counter (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             last,
  input  logic [7:0]       ch,
  output rsc_pkg::counts_t counts_next
);
  import rsc_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STOP  = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  function automatic logic is_mark(logic [7:0] b);
    return b == CH_BANG || b == CH_QUERY || b == CH_SEMI || b == CH_COLON || b == CH_STOP;
  endfunction

  function automatic logic is_vowel(logic [7:0] b);
    logic [7:0] lc;
    lc = b | 8'h20;
    // fold case only for letters; 0x40..0x5F / 0x60..0x7F share the low bits
    return (b[7:6] == 2'b01) &&
           (lc == 8'h61 || lc == 8'h65 || lc == 8'h69 ||
            lc == 8'h6F || lc == 8'h75 || lc == 8'h79);
  endfunction

  function automatic count_t sat_inc(count_t x);
    return (x == '1) ? x : COUNT_BITS'(x + 1'b1);
  endfunction

  logic [7:0] prev_byte;
  logic       first_space_pending;
  counts_t    counts;
  logic       pending_next;

  always_comb begin
    counts_next  = counts;
    pending_next = first_space_pending;
    if (ch == CH_SPACE) begin
      if (first_space_pending) begin
        counts_next.words = sat_inc(counts_next.words);
      end
      counts_next.words = sat_inc(counts_next.words);
      pending_next      = 1'b0;
    end
    if (is_mark(ch) && !is_mark(prev_byte)) begin
      counts_next.sentences = sat_inc(counts.sentences);
    end
    if (is_vowel(ch)) begin
      counts_next.vowels = sat_inc(counts.vowels);
      if (is_vowel(prev_byte)) begin
        counts_next.pairs = sat_inc(counts.pairs);
      end
    end
    // silent e: drop one vowel, never below zero
    if ((prev_byte == CH_LOW_E || prev_byte == CH_UP_E) &&
        (ch == CH_SPACE || ch == CH_STOP) && counts.vowels != '0) begin
      counts_next.vowels = COUNT_BITS'(counts.vowels - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      prev_byte           <= '0;
      first_space_pending <= 1'b1;
      counts              <= '0;
    end else if (accept) begin
      prev_byte           <= ch;
      first_space_pending <= pending_next;
      counts              <= counts_next;
    end
  end

endmodule

### rtl/rsc_divider.sv
// Restoring divider, one quotient bit per cycle.
module rsc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rsc_pkg::DIV_NUM_W-1:0] num,
  input  logic [rsc_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [rsc_pkg::DIV_NUM_W-1:0] quotient
);
  import rsc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  always_comb begin
    shifted = {rem[DIV_DEN_W-1:0], quotient[DIV_NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= DIV_CNT_W'(cnt + 1'b1);
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den_q    <= den;
      quotient <= num;
    end else if (busy) begin
      rem      <= fits ? (shifted - {1'b0, den_q}) : shifted;
      quotient <= {quotient[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

### tb/testbench.sv
// Self-checking bench for the readability score counter: random text bytes, checked reports.
`timescale 1ns / 100ps

module testbench;
  import rsc_pkg::*;

  typedef logic [7:0] text_t[$];

  // One report as it leaves the result channel
  typedef struct packed {
    logic [23:0] score;
    logic [23:0] words;
    logic [23:0] sentences;
    logic [23:0] syllables;
    logic [1:0]  error;
  } score_report_t;

  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  // Margin for stray reports after the last owed one
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AFTER   = 15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STOP  = 8'h2E;

  // Score arithmetic in Q15.8: base 206.835, gains 84.6*256*10 and 1.015*256*100
  localparam longint EASE_BASE     = 52950;
  localparam longint SYL_GAIN      = 216576;
  localparam longint SENT_GAIN     = 25984;
  localparam longint SCORE_CEIL    = 8388607;
  localparam longint SCORE_FLOOR   = -8388608;
  localparam longint FIELD_CEIL    = 64'hFFFFFF;

  // Running Flesch counts for the text in flight, plus the reports still owed
  class ease_ledger;
    logic [7:0]    prev_byte;
    bit            space_pending;
    count_t        words;
    count_t        sentences;
    count_t        vowels;
    count_t        pairs;
    score_report_t awaited[$];
    int            failures;

    function new();
      failures = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      prev_byte     = 8'h00;
      space_pending = 1'b1;
      words         = '0;
      sentences     = '0;
      vowels        = '0;
      pairs         = '0;
    endfunction

    function count_t bump(count_t x);
      return (x == '1) ? x : x + 1'b1;
    endfunction

    function bit is_mark(logic [7:0] c);
      case (c)
        "!", "?", ";", ":", ".": return 1'b1;
        default:                 return 1'b0;
      endcase
    endfunction

    function bit is_vowel(logic [7:0] c);
      case (c)
        "a", "e", "i", "o", "u", "y",
        "A", "E", "I", "O", "U", "Y": return 1'b1;
        default:                      return 1'b0;
      endcase
    endfunction

    function longint unsigned to_field(longint unsigned v);
      return (v > FIELD_CEIL) ? FIELD_CEIL : v;
    endfunction

    // Count one accepted byte; on the last byte of a text, owe a report
    function void note_byte(logic [7:0] c, logic is_last);
      longint unsigned w, n, s, t1, t2;
      longint          sc;
      score_report_t   rep;
      if (c == CH_SPACE) begin
        if (space_pending) begin
          words = bump(words);
          space_pending = 1'b0;
        end
        words = bump(words);
      end
      if (is_mark(c) && !is_mark(prev_byte))
        sentences = bump(sentences);
      if (is_vowel(c)) begin
        vowels = bump(vowels);
        if (is_vowel(prev_byte))
          pairs = bump(pairs);
      end
      if ((prev_byte == "e" || prev_byte == "E") && (c == CH_SPACE || c == CH_STOP)) begin
        if (vowels != '0)
          vowels = vowels - 1'b1;
      end
      prev_byte = c;
      if (!is_last)
        return;

      w = words;
      n = sentences;
      s = (vowels > pairs) ? vowels - pairs : 0;
      if (s < w)
        s = w;
      sc = 0;
      if (w == 0) begin
        rep.error = ERR_NO_WORDS;
      end else if (n == 0) begin
        rep.error = ERR_NO_SENTENCES;
      end else begin
        rep.error = ERR_OK;
        t1 = (2 * SYL_GAIN * s + 10 * w) / (20 * w);
        t2 = (2 * SENT_GAIN * w + 100 * n) / (200 * n);
        sc = EASE_BASE - longint'(t1) - longint'(t2);
        if (sc > SCORE_CEIL)
          sc = SCORE_CEIL;
        if (sc < SCORE_FLOOR)
          sc = SCORE_FLOOR;
      end
      rep.score     = sc[23:0];
      rep.words     = 24'(to_field(w));
      rep.sentences = 24'(to_field(n));
      rep.syllables = 24'(to_field(s));
      awaited.push_back(rep);
      clear_counts();
    endfunction

    function void match_report(score_report_t got);
      score_report_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: report with nothing owed: score %0d words %0d sent %0d syl %0d err %0d",
                   $realtime, $signed(got.score), got.words, got.sentences, got.syllables,
                   got.error);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: report mismatch (expected/actual): score %0d/%0d words %0d/%0d",
                   $realtime, $signed(want.score), $signed(got.score), want.words,
                   got.words);
          $display("  sent %0d/%0d syl %0d/%0d err %0d/%0d",
                   want.sentences, got.sentences, want.syllables, got.syllables,
                   want.error, got.error);
        end
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        failures += awaited.size();
        $display("%0d reports never arrived", awaited.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsc_in_if  text_ch ();
  rsc_out_if result_ch ();

  readability_score_counter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  ease_ledger ledger = new();

  int bytes_sent    = 0;
  int reports_taken = 0;
  int cycle_count   = 0;

  always #5 clk = ~clk;

  // Hold the run to a hard ceiling in case the block wedges
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("readability_score_counter_unit verification failed");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic text_t spell(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++)
      t.push_back(s[i]);
    return t;
  endfunction

  // Prose-like byte: vowels, consonants, spaces, sentence marks, a few stray bytes
  function automatic logic [7:0] prose_byte();
    string vowel_set = "aeiouyAEIOUY";
    string other_set = "bcdfghlmnrstvBST";
    string mark_set  = "!?;:.";
    int    r;
    r = $urandom_range(0, 99);
    if (r < 30)
      return vowel_set[$urandom_range(0, vowel_set.len() - 1)];
    if (r < 54)
      return other_set[$urandom_range(0, other_set.len() - 1)];
    if (r < 70)
      return CH_SPACE;
    if (r < 80)
      return mark_set[$urandom_range(0, mark_set.len() - 1)];
    if (r < 90)
      return ($urandom_range(0, 1) != 0) ? 8'(CH_STOP) : 8'("e");
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer a whole text, one transfer per byte, last on the final byte.
  // Drop valid only when a gap is taken, so back-to-back bytes keep it high.
  task automatic send_text(input text_t t, input bit burst);
    int gap;
    for (int i = 0; i < t.size(); i++) begin
      gap = burst ? 0 : gap_length();
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      text_ch.valid <= 1'b1;
      text_ch.ch    <= t[i];
      text_ch.last  <= (i == t.size() - 1);
      do @(posedge clk); while (!text_ch.ready);
      ledger.note_byte(t[i], i == t.size() - 1);
      bytes_sent++;
    end
  endtask

  // Result side: take reports, alternate steady and choppy stretches of ready,
  // and once, after a few reports, hold off long enough to back the block up
  // into its text input.
  initial begin : result_side
    int  mode_left;
    int  hold_left;
    bit  choppy;
    bit  long_hold_done;
    mode_left      = 0;
    hold_left      = 0;
    choppy         = 1'b0;
    long_hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        if (result_ch.valid && result_ch.ready) begin
          ledger.match_report({result_ch.score, result_ch.words, result_ch.sentences,
                               result_ch.syllables, result_ch.error});
          reports_taken++;
        end
        if (mode_left == 0) begin
          choppy    = ($urandom_range(0, 1) != 0);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        if (!long_hold_done && reports_taken == HOLD_AFTER) begin
          long_hold_done = 1'b1;
          hold_left      = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          result_ch.ready <= 1'b0;
        end else if (choppy && $urandom_range(0, 99) < 40) begin
          hold_left = gap_length();
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : text_side
    text_t t;
    int    len;
    bit    noisy;
    text_ch.valid <= 1'b0;
    text_ch.ch    <= 8'h00;
    text_ch.last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: lone extreme bytes with no words, words with no sentence
    // (syllables raised to the word count), then silent e before space and
    // full stop, diphthongs, the first space counting twice and runs of marks.
    send_text('{8'h00}, 1'b0);
    send_text('{8'hFF}, 1'b1);
    send_text(spell("a b"), 1'b1);
    send_text(spell("Eye see. Yo!:"), 1'b0);
    send_text('{8'hFF, CH_SPACE, "I", "O", ";", "?"}, 1'b1);

    // Random texts: mostly prose of short length, some long, some pure noise
    while (bytes_sent < ITEM_TARGET) begin
      len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 90);
      noisy = ($urandom_range(0, 99) < 20);
      t.delete();
      for (int i = 0; i < len; i++)
        t.push_back(noisy ? 8'($urandom_range(0, 255)) : prose_byte());
      send_text(t, $urandom_range(0, 99) < 30);
    end
    text_ch.valid <= 1'b0;

    // Drain: wait for every owed report, then a margin for stray ones
    while (ledger.awaited.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    ledger.close_out();
    if (ledger.failures == 0)
      $display("readability_score_counter_unit verification clean");
    else
      $display("readability_score_counter_unit verification failed");
    $finish;
  end

endmodule
